// ===== src/rssi_descending_record_sorter_assert.svh =====
// Assertion shorthands for the record sorter. Both are clocked on the rising edge of clock
// and are held off while reset is high.
`ifndef RSSI_DESCENDING_RECORD_SORTER_ASSERT_SVH
`define RSSI_DESCENDING_RECORD_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDSRT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDSRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rdsrt_pkg.sv =====
package rdsrt_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic signed [7:0] dbm;
      logic [7:0]        channel;
      logic              open_net;
      logic [7:0]        tag;
   } rec_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      rec_type data;
   } wr_port_type;

   // Bar map: bars = (dbm + 90) * 4 / 50 + 1, clamped to 1..5.
   // Bar k is reached once (dbm + 90) * 4 >= (k - 1) * 50.
   localparam int DBM_OFFSET = 90;
   localparam int BAR_NUM    = 4;
   localparam int BAR_DEN    = 50;
   localparam int BAR2_DBM   = (1 * BAR_DEN + BAR_NUM - 1) / BAR_NUM - DBM_OFFSET;
   localparam int BAR3_DBM   = (2 * BAR_DEN + BAR_NUM - 1) / BAR_NUM - DBM_OFFSET;
   localparam int BAR4_DBM   = (3 * BAR_DEN + BAR_NUM - 1) / BAR_NUM - DBM_OFFSET;
   localparam int BAR5_DBM   = (4 * BAR_DEN + BAR_NUM - 1) / BAR_NUM - DBM_OFFSET;

   localparam logic [1:0] CLASS_WEAK   = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_STRONG = 2'd2;

   localparam logic [2:0] BARS_MEDIUM = 3'd2;
   localparam logic [2:0] BARS_STRONG = 3'd4;

   function automatic logic [2:0] bars_of(input logic signed [7:0] dbm);
      int d;
      logic [2:0] bars;
      d = int'(dbm);
      if (d >= BAR5_DBM) begin
         bars = 3'd5;
      end else if (d >= BAR4_DBM) begin
         bars = 3'd4;
      end else if (d >= BAR3_DBM) begin
         bars = 3'd3;
      end else if (d >= BAR2_DBM) begin
         bars = 3'd2;
      end else begin
         bars = 3'd1;
      end
      return bars;
   endfunction

   function automatic logic [1:0] class_of(input logic [2:0] bars);
      logic [1:0] cls;
      if (bars >= BARS_STRONG) begin
         cls = CLASS_STRONG;
      end else if (bars >= BARS_MEDIUM) begin
         cls = CLASS_MEDIUM;
      end else begin
         cls = CLASS_WEAK;
      end
      return cls;
   endfunction

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_READ,
      ST_COMPARE,
      ST_SWAP,
      ST_ADVANCE,
      ST_EMIT_INIT,
      ST_EMIT_WAIT,
      ST_EMIT,
      ST_EMIT_NEXT,
      ST_CLEAR
   } step_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_RESTART,
      OP_COMPARE,
      OP_SWAP,
      OP_ADVANCE,
      OP_EMIT,
      OP_CLEAR
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_WAIT_SCAN,
      C_FEW,
      C_NO_SWAP,
      C_SORT_MORE,
      C_EMPTY,
      C_OUT_BUSY,
      C_EMIT_MORE
   } cond_type;

   typedef struct packed {
      logic     ready;
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // Microprogram. A step falls through to the next one unless its condition holds,
   // in which case it jumps to the target.
   function automatic ctrl_type ucode(input step_type step);
      ctrl_type cw;
      unique case (step)
         ST_LOAD:      cw = '{1'b1, OP_LOAD,    C_WAIT_SCAN, ST_LOAD};
         ST_SORT_INIT: cw = '{1'b0, OP_RESTART, C_FEW,       ST_EMIT_INIT};
         ST_READ:      cw = '{1'b0, OP_NONE,    C_NEVER,     ST_READ};
         ST_COMPARE:   cw = '{1'b0, OP_COMPARE, C_NO_SWAP,   ST_ADVANCE};
         ST_SWAP:      cw = '{1'b0, OP_SWAP,    C_NEVER,     ST_ADVANCE};
         ST_ADVANCE:   cw = '{1'b0, OP_ADVANCE, C_SORT_MORE, ST_READ};
         ST_EMIT_INIT: cw = '{1'b0, OP_RESTART, C_EMPTY,     ST_CLEAR};
         ST_EMIT_WAIT: cw = '{1'b0, OP_NONE,    C_NEVER,     ST_EMIT};
         ST_EMIT:      cw = '{1'b0, OP_EMIT,    C_OUT_BUSY,  ST_EMIT};
         ST_EMIT_NEXT: cw = '{1'b0, OP_NONE,    C_EMIT_MORE, ST_EMIT};
         ST_CLEAR:     cw = '{1'b0, OP_CLEAR,   C_ALWAYS,    ST_LOAD};
         default:      cw = '{1'b0, OP_NONE,    C_ALWAYS,    ST_LOAD};
      endcase
      return cw;
   endfunction

endpackage

// ===== src/rdsrt_store.sv =====
module rdsrt_store
   import rdsrt_pkg::*;
(
   input  logic        clock,
   input  wr_port_type wr,
   input  idx_type     rd_addr_a,
   input  idx_type     rd_addr_b,
   output rec_type     rd_data_a,
   output rec_type     rd_data_b
);

   rec_type mem_ff [MAX_ENTRIES];
   rec_type rd_a_ff;
   rec_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   // Both read ports return the contents from before a write in the same cycle.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/rssi_descending_record_sorter.sv =====
// Records load at one input transaction per cycle. After the final transaction of a scan
// with n records, a setup step and n*(n-1)/2 compares follow, each a read, compare and advance
// step plus a swap step when the pair swaps, as a swap needs two writes to the single write
// port of the store. Emission then runs ST_EMIT_INIT, ST_EMIT_WAIT, then ST_EMIT (held on
// rsp_tready stalls) and ST_EMIT_NEXT per record; ST_CLEAR empties the store before a new scan is accepted.
// Reset clears the step counter, the record count and the output valid, not the store.
`include "rssi_descending_record_sorter_assert.svh"

module rssi_descending_record_sorter
   import rdsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // signal_dbm, radio_channel, open_net, entry_tag
   input  logic        req_tuser,   // has_entry
   input  logic        req_tlast,   // scan_done
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_signal_dbm, out_channel, out_open, out_tag,
                                    // bar_count, strength_class
   output logic        rsp_tlast    // run_last
);

   step_type    step_ff, step_in;
   cnt_type     count_ff, count_in;
   idx_type     i_ff, i_in;
   idx_type     j_ff, j_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rec_type     rsp_rec_ff, rsp_rec_in;
   logic [2:0]  rsp_bars_ff, rsp_bars_in;
   logic [1:0]  rsp_class_ff, rsp_class_in;
   logic        rsp_last_ff, rsp_last_in;

   ctrl_type    cw;
   wr_port_type wr;
   rec_type     rd_a;
   rec_type     rd_b;
   rec_type     in_rec;
   logic        accept;
   logic        room;
   logic        swap;
   logic        out_free;
   logic        j_last;
   logic        sort_done;
   logic        emit_last;
   logic        jump;
   logic [2:0]  bars;

   rdsrt_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_addr_a (i_ff),
      .rd_addr_b (j_ff),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_bars_ff  <= rsp_bars_in;
      rsp_class_ff <= rsp_class_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      cw        = ucode(step_ff);
      accept    = req_tvalid && cw.ready;
      room      = count_ff < cnt_type'(MAX_ENTRIES);
      swap      = $signed(rd_b.dbm) > $signed(rd_a.dbm);
      out_free  = !rsp_valid_ff || rsp_tready;
      j_last    = (cnt_type'(j_ff) + cnt_type'(1)) == count_ff;
      sort_done = j_last && ((cnt_type'(i_ff) + cnt_type'(2)) == count_ff);
      emit_last = (cnt_type'(i_ff) + cnt_type'(1)) == count_ff;
      bars      = bars_of(rd_a.dbm);

      in_rec.dbm      = req_tdata[7:0];
      in_rec.channel  = req_tdata[15:8];
      in_rec.open_net = req_tdata[16];
      in_rec.tag      = req_tdata[24:17];

      unique case (cw.cond)
         C_NEVER:     jump = 1'b0;
         C_ALWAYS:    jump = 1'b1;
         C_WAIT_SCAN: jump = !(accept && req_tlast);
         C_FEW:       jump = count_ff < cnt_type'(2);
         C_NO_SWAP:   jump = !swap;
         C_SORT_MORE: jump = !sort_done;
         C_EMPTY:     jump = count_ff == '0;
         C_OUT_BUSY:  jump = !out_free;
         C_EMIT_MORE: jump = !rsp_last_ff;
         default:     jump = 1'b1;
      endcase
      step_in = jump ? cw.target : step_type'(step_ff + 4'd1);

      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      wr.en        = 1'b0;
      wr.addr      = i_ff;
      wr.data      = rd_b;
      rsp_rec_in   = rsp_rec_ff;
      rsp_bars_in  = rsp_bars_ff;
      rsp_class_in = rsp_class_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (cw.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            if (accept && req_tuser && room) begin
               wr.en    = 1'b1;
               wr.addr  = count_ff[IDX_W-1:0];
               wr.data  = in_rec;
               count_in = count_ff + cnt_type'(1);
            end
         end
         OP_RESTART: begin
            i_in = '0;
            j_in = idx_type'(1);
         end
         OP_COMPARE: begin
            // The lower slot takes the stronger record now; the upper slot is written
            // in the following step from the still-registered old value of the lower slot.
            wr.en = swap;
         end
         OP_SWAP: begin
            wr.en   = 1'b1;
            wr.addr = j_ff;
            wr.data = rd_a;
         end
         OP_ADVANCE: begin
            if (j_last) begin
               i_in = i_ff + idx_type'(1);
               j_in = i_ff + idx_type'(2);
            end else begin
               j_in = j_ff + idx_type'(1);
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = rd_a;
               rsp_bars_in  = bars;
               rsp_class_in = class_of(bars);
               rsp_last_in  = emit_last;
               i_in         = i_ff + idx_type'(1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign req_tready = cw.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_class_ff, rsp_bars_ff, rsp_rec_ff.tag,
                        rsp_rec_ff.open_net, rsp_rec_ff.channel, rsp_rec_ff.dbm};

   `RDSRT_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= cnt_type'(MAX_ENTRIES),
                      "record count beyond capacity")
   `RDSRT_ASSERT_IMPL(a_pair_order, step_ff == ST_COMPARE,
                      (i_ff < j_ff) && (cnt_type'(j_ff) < count_ff), "compared pair out of range")
   `RDSRT_ASSERT_IMPL(a_swap_after_cmp, step_ff == ST_SWAP, $past(step_ff) == ST_COMPARE,
                      "swap write without a compare")
   `RDSRT_ASSERT_NEXT(a_clear_empties, step_ff == ST_CLEAR,
                      (count_ff == '0) && (step_ff == ST_LOAD), "store not emptied after a scan")

endmodule
